@@ hdl/lpct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpct_pkg: shared types and constants of the linear probe count table
// Field widths, hash mapping constants, queue sizing, opcodes and the
// item and result records passed between the front, queue and back.
// ----------------------------------------------------------------------------
package lpct_pkg;

    // Table geometry (slot count is a power of two)
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);

    // Field widths
    localparam int OP_W       = 2;
    localparam int HASH_W     = 64;
    localparam int CNT_W      = 31;
    localparam int SLOT_OUT_W = 10;
    localparam int RAM_W      = HASH_W + CNT_W;

    // Stream widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;

    // Home slot mapping: ((MULT_K*h + ADD_K) mod 2^64 mod MOD_K) mod TABLE_SLOTS
    localparam logic [19:0] MULT_K = 20'd939565;
    localparam logic [31:0] ADD_K  = 32'd4040123209;
    localparam logic [29:0] MOD_K  = 30'd1041530473;

    // Reciprocal floor(2^64 / MOD_K) for the quotient estimate
    localparam logic [127:0] RECIP_FULL = (128'd1 << 64) / 128'(MOD_K);
    localparam logic [34:0]  RECIP_K    = RECIP_FULL[34:0];

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Front-to-back queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_OUT
    } back_state_t;

    // Classified item: opcode, key hash and home slot
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [HASH_W-1:0] hash;
        logic [SLOT_W-1:0] home;
    } probe_req_t;

    // Result record, count in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]      total_puts;
        logic                  table_full;
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic [CNT_W-1:0]      count;
    } result_t;

    localparam int RES_W   = $bits(result_t);
    localparam int M_PAD_W = M_TDATA_W - RES_W;

endpackage

@@ hdl/lpct_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpct_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lpct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/lpct_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpct_front: item intake and home slot pipeline
// Seven register stages turn the key hash into its home slot with
// split multiplies and a reciprocal modulo; the result is pushed to the queue.
// ----------------------------------------------------------------------------
module lpct_front import lpct_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [OP_W-1:0]   s_opcode,
    input  logic [HASH_W-1:0] s_key_hash,
    input  logic              init_done,
    input  logic              fifo_full,
    output logic              push,
    output probe_req_t        push_req
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic adv;

    logic [OP_W-1:0]   op1_reg, op2_reg, op3_reg, op4_reg, op5_reg, op6_reg, op7_reg;
    logic [HASH_W-1:0] h1_reg, h2_reg, h3_reg, h4_reg, h5_reg, h6_reg, h7_reg;

    logic [52:0] plo_next, plo2_reg, plo3_reg;
    logic [51:0] phi_prod;
    logic [31:0] phi3_reg;
    logic [63:0] t_next, t4_reg, t5_reg;
    logic [66:0] pl_next, pl5_reg;
    logic [67:0] qs_next;
    logic [31:0] qlo6_reg, tl6_reg;
    logic [61:0] qm_prod;
    logic [31:0] r_next, r7_reg, r_fix;

    // Advance unless the last stage holds an item the queue cannot take
    assign adv      = !(v7_reg && fifo_full);
    assign s_tready = adv && init_done;

    always_comb begin
        plo_next = 53'(h1_reg[31:0]) * 53'(MULT_K) + 53'(ADD_K);
        phi_prod = 52'(h2_reg[63:32]) * 52'(MULT_K);
        t_next   = 64'(plo3_reg) + {phi3_reg, 32'd0};
        pl_next  = 67'(t4_reg[31:0]) * 67'(RECIP_K);
        qs_next  = 68'(t5_reg[63:32]) * 68'(RECIP_K) + 68'(pl5_reg[66:32]);
        qm_prod  = 62'(qlo6_reg) * 62'(MOD_K);
        r_next   = tl6_reg - qm_prod[31:0];
        // Quotient estimate is short by at most one
        r_fix    = (r7_reg >= 32'(MOD_K)) ? r7_reg - 32'(MOD_K) : r7_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid && s_tready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg  <= s_opcode;
            h1_reg   <= s_key_hash;
            op2_reg  <= op1_reg;
            h2_reg   <= h1_reg;
            plo2_reg <= plo_next;
            op3_reg  <= op2_reg;
            h3_reg   <= h2_reg;
            plo3_reg <= plo2_reg;
            phi3_reg <= phi_prod[31:0];
            op4_reg  <= op3_reg;
            h4_reg   <= h3_reg;
            t4_reg   <= t_next;
            op5_reg  <= op4_reg;
            h5_reg   <= h4_reg;
            t5_reg   <= t4_reg;
            pl5_reg  <= pl_next;
            op6_reg  <= op5_reg;
            h6_reg   <= h5_reg;
            qlo6_reg <= qs_next[63:32];
            tl6_reg  <= t5_reg[31:0];
            op7_reg  <= op6_reg;
            h7_reg   <= h6_reg;
            r7_reg   <= r_next;
        end
    end

    assign push          = v7_reg && !fifo_full;
    assign push_req.op   = op7_reg;
    assign push_req.hash = h7_reg;
    assign push_req.home = SLOT_W'(r_fix % 32'(TABLE_SLOTS));

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (v7_reg && !adv) |=> v7_reg)
        else $error("front: stalled item left the last stage");

endmodule

@@ hdl/lpct_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpct_fifo: short queue of classified items
// Decouples the hash pipeline from the probe engine.
// ----------------------------------------------------------------------------
module lpct_fifo import lpct_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  probe_req_t push_req,
    input  logic       pop,
    output probe_req_t head,
    output logic       full,
    output logic       empty
);

    probe_req_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     cnt_reg;

    assign full  = cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("fifo: push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("fifo: pop while empty");

endmodule

@@ hdl/lpct_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpct_back: probe engine
// Clears the slot memory after reset, then walks each item's probe chain one slot
// per cycle, updates the stopping slot on a put or remove, fills the result register.
// ----------------------------------------------------------------------------
module lpct_back import lpct_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fifo_empty,
    input  probe_req_t head,
    output logic       pop,
    output logic       init_done,
    output logic       m_tvalid,
    input  logic       m_tready,
    output result_t    m_res
);

    back_state_t state_reg, state_next;

    logic [SLOT_W-1:0] clr_reg;
    logic [OP_W-1:0]   op_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [SLOT_W-1:0] home_reg, idx_reg, lap_reg, res_idx_reg;
    logic [CNT_W-1:0]  res_count_reg, put_total_reg, put_total_next;
    logic              res_hit_reg, res_full_reg, pend_we_reg, pend_put_reg;
    logic [RAM_W-1:0]  pend_wdata_reg;
    logic              m_tvalid_reg;
    result_t           m_res_reg;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    logic [RAM_W-1:0]  ram_wdata, ram_rdata;

    logic [CNT_W-1:0]  rd_count, new_count;
    logic [HASH_W-1:0] rd_hash;
    logic              hash_eq, stop, lap_end, is_put, is_remove, out_free, out_load;
    logic [SLOT_W-1:0] idx_inc;
    logic [SLOT_W+SLOT_OUT_W-1:0] idx_wide;

    lpct_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Probe decision on the slot read last cycle
    always_comb begin
        rd_count  = ram_rdata[CNT_W-1:0];
        rd_hash   = ram_rdata[RAM_W-1:CNT_W];
        hash_eq   = rd_hash == hash_reg;
        stop      = (rd_count == '0) || hash_eq;
        lap_end   = lap_reg == SLOT_W'(TABLE_SLOTS - 1);
        idx_inc   = (idx_reg == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : idx_reg + 1'b1;
        is_put    = op_reg == OP_PUT;
        is_remove = op_reg == OP_REMOVE;
        if (is_put) begin
            new_count = (rd_count == CNT_MAX) ? rd_count : rd_count + 1'b1;
        end else if (is_remove) begin
            new_count = '0;
        end else begin
            new_count = rd_count;
        end
        out_free       = !m_tvalid_reg || m_tready;
        put_total_next = (pend_put_reg && (put_total_reg != CNT_MAX)) ?
                         put_total_reg + 1'b1 : put_total_reg;
        idx_wide       = (SLOT_W+SLOT_OUT_W)'(res_idx_reg);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR: begin
                if (clr_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!fifo_empty) begin
                    state_next = B_PROBE;
                end
            end
            B_PROBE: begin
                if (stop || lap_end) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_CLEAR;
        endcase
    end

    // Outputs and memory controls
    always_comb begin
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = pend_wdata_reg;
        ram_raddr = idx_reg;
        out_load  = 1'b0;
        init_done = 1'b1;
        unique case (state_reg)
            B_CLEAR: begin
                init_done = 1'b0;
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {{HASH_W{1'b1}}, {CNT_W{1'b0}}};
            end
            B_IDLE: begin
                pop       = !fifo_empty;
                ram_raddr = head.home;
            end
            B_PROBE: begin
                ram_raddr = idx_inc;
            end
            B_OUT: begin
                out_load = out_free;
                ram_we   = out_free && pend_we_reg;
            end
            default: init_done = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            put_total_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (out_load) begin
                put_total_reg <= put_total_next;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            op_reg   <= head.op;
            hash_reg <= head.hash;
            home_reg <= head.home;
            idx_reg  <= head.home;
            lap_reg  <= '0;
        end
        if (state_reg == B_PROBE) begin
            if (stop) begin
                res_count_reg  <= new_count;
                res_hit_reg    <= (rd_count != '0) && hash_eq;
                res_full_reg   <= 1'b0;
                res_idx_reg    <= idx_reg;
                pend_we_reg    <= is_put || is_remove;
                pend_put_reg   <= is_put;
                pend_wdata_reg <= is_put ? {hash_reg, new_count} : {rd_hash, {CNT_W{1'b0}}};
            end else if (lap_end) begin
                // Full lap: report the home slot, change nothing
                res_count_reg <= '0;
                res_hit_reg   <= 1'b0;
                res_full_reg  <= 1'b1;
                res_idx_reg   <= home_reg;
                pend_we_reg   <= 1'b0;
                pend_put_reg  <= 1'b0;
            end else begin
                idx_reg <= idx_inc;
                lap_reg <= lap_reg + 1'b1;
            end
        end
        if (out_load) begin
            m_res_reg.count      <= res_count_reg;
            m_res_reg.slot       <= idx_wide[SLOT_OUT_W-1:0];
            m_res_reg.hit        <= res_hit_reg;
            m_res_reg.table_full <= res_full_reg;
            m_res_reg.total_puts <= put_total_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_res    = m_res_reg;

    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_CLEAR) |-> !pop)
        else $error("back: item taken during clearing pass");

    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (put_total_reg >= $past(put_total_reg)))
        else $error("back: put total decreased");

endmodule

@@ hdl/linear_probe_count_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_count_table_top: occurrence-count table with linear probing
// Counts keys by 64-bit hash in a 1024-slot open-addressing table.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload (lowest bit first)
// s_*       in   s_tvalid/s_tready  opcode[1:0], key_hash[65:2], zero pad
// m_*       out  m_tvalid/m_tready  count[30:0], slot[40:31], hit[41],
//                                   table_full[42], total_puts[73:43], zero pad
//
// Flow: the front takes one item per cycle, unless its last stage is held by a
//   full queue or clearing runs, into a seven-stage home slot pipeline; the probe
//   engine reads one slot per cycle along an item's chain, and this sets the rate.
// Reset: after aresetn rises, a clearing pass sets every slot's count to
//   zero; s_tready stays low until it ends.
// Stalls: a four-entry queue sits between front and engine, and the result
//   register lets the engine start the next item while a result waits.
// ----------------------------------------------------------------------------
module linear_probe_count_table_top import lpct_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // opcode, key_hash
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // count, slot, hit, table_full, total_puts
);

    logic       init_done;
    logic       fifo_full, fifo_empty;
    logic       push, pop;
    probe_req_t push_req, head;
    result_t    res;

    // Hash the key and find its home slot
    lpct_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_opcode   (s_tdata[OP_W-1:0]),
        .s_key_hash (s_tdata[OP_W+HASH_W-1:OP_W]),
        .init_done  (init_done),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_req   (push_req)
    );

    // Buffer classified items so each side can stall on its own
    lpct_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // Walk the probe chain, update the slot, produce the result
    lpct_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .init_done  (init_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (res)
    );

    // Pack the result record, pad to whole bytes
    assign m_tdata = {{M_PAD_W{1'b0}}, res};

endmodule
